/* src/bllk_pkg.sv */
// Package for the lateral leg kinematics block: widths, cell data types,
// CORDIC angle table and output rounding helpers. No dependencies.
package bllk_pkg;

  localparam int POS_W   = 24;  // hip position / foot center, Q16 signed
  localparam int REG_W   = 18;  // unsigned length registers, Q16
  localparam int OUT_W   = 18;  // roll / length outputs
  localparam int CFG_W   = 24;  // widest register
  localparam int IDX_W   = 2;   // register index
  localparam int DIFF_W  = 26;  // position minus right foot center
  localparam int OFS_W   = 21;  // doubled offset, signed
  localparam int HGT_W   = 20;  // doubled height, unsigned
  localparam int MAG_W   = 20;  // |doubled offset|
  localparam int CW      = 32;  // CORDIC x, y, z width
  localparam int SQ_W    = 40;  // radicand width
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int ROOT_W  = SQ_STEPS;
  localparam int REM_W   = 22;
  localparam int ROLL_LIMIT = 102944;
  localparam int LEN_MAX    = 262143;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_HIP_HEIGHT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_STEP_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HIP_WIDTH   = 2'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT_FOOT  = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // atan(2^-i) scaled by 2^30, floored
  function automatic logic signed [CW-1:0] atan_step(input int i);
    logic signed [CW-1:0] a;
    a = '0;
    unique case (i)
      0: a = 32'sd843314856;
      1: a = 32'sd497837829;
      2: a = 32'sd263043836;
      3: a = 32'sd133525158;
      4: a = 32'sd67021686;
      5: a = 32'sd33543515;
      6: a = 32'sd16775850;
      7: a = 32'sd8388437;
      8: a = 32'sd4194282;
      9: a = 32'sd2097149;
      default: begin
        if (i <= 30) a = (32'sd1 <<< (30 - i)) - 32'sd1;
        else a = '0;
      end
    endcase
    return a;
  endfunction

  // Round z (2^30 rad) to Q16 and clamp
  function automatic logic [OUT_W-1:0] roll_of(input logic signed [CW-1:0] z);
    logic signed [CW-1:0] r;
    logic [OUT_W-1:0] q;
    r = (z + 32'sd8192) >>> 14;
    if (r > 32'sd102944) q = 18'(ROLL_LIMIT);
    else if (r < -32'sd102944) q = 18'(-ROLL_LIMIT);
    else q = r[OUT_W-1:0];
    return q;
  endfunction

  // Halve the doubled root with rounding and saturate
  function automatic logic [OUT_W-1:0] length_of(input logic [ROOT_W-1:0] root);
    logic [ROOT_W:0] s;
    logic [ROOT_W-1:0] l;
    s = {1'b0, root} + (ROOT_W+1)'(1);
    l = s[ROOT_W:1];
    return (l > ROOT_W'(LEN_MAX)) ? OUT_W'(LEN_MAX) : l[OUT_W-1:0];
  endfunction

endpackage

/* src/bllk_if.sv */
// Channel interfaces for the lateral leg kinematics block.
// Depends on bllk_pkg for field widths.
interface bllk_pos_if import bllk_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [POS_W-1:0] hip_position;
  modport source (output valid, hip_position, input ready);
  modport sink (input valid, hip_position, output ready);
endinterface

interface bllk_set_if import bllk_pkg::*; ();
  logic valid;
  logic ready;
  logic in_range;
  logic signed [OUT_W-1:0] left_roll;
  logic signed [OUT_W-1:0] right_roll;
  logic [OUT_W-1:0] left_length;
  logic [OUT_W-1:0] right_length;
  modport source (output valid, in_range, left_roll, right_roll, left_length,
                  right_length, input ready);
  modport sink (input valid, in_range, left_roll, right_roll, left_length,
                right_length, output ready);
endinterface

/* src/bllk_cordic_cell.sv */
// One CORDIC vectoring micro-rotation, registered.
// Depends on bllk_pkg (cord_t, atan_step).
module bllk_cordic_cell import bllk_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  cord_t prev,
  output cord_t cur
);

  localparam logic signed [CW-1:0] ANGLE = atan_step(STAGE);

  logic signed [CW-1:0] dx, dy;

  // shifted cross terms from the previous cell
  always_comb begin
    dx = $signed(prev.y) >>> STAGE;
    dy = $signed(prev.x) >>> STAGE;
  end

  // rotate toward y = 0
  always_ff @(posedge clk) begin
    if ($signed(prev.y) > 0) begin
      cur.x <= prev.x + dx;
      cur.y <= prev.y - dy;
      cur.z <= prev.z + ANGLE;
    end else begin
      cur.x <= prev.x - dx;
      cur.y <= prev.y + dy;
      cur.z <= prev.z - ANGLE;
    end
  end

endmodule

/* src/bllk_sqrt_cell.sv */
// One restoring square-root step (one root bit), registered.
// Depends on bllk_pkg (sq_t).
module bllk_sqrt_cell import bllk_pkg::*; (
  input  logic clk,
  input  sq_t  prev,
  output sq_t  cur
);

  logic [REM_W:0] part;
  logic [REM_W:0] trial;

  // bring down the next bit pair, trial subtract 4*root+1
  always_comb begin
    part  = {prev.rem[REM_W-2:0], prev.n[SQ_W-1 -: 2]};
    trial = {1'b0, prev.root, 2'b01};
  end

  always_ff @(posedge clk) begin
    cur.n <= {prev.n[SQ_W-3:0], 2'b00};
    if (part >= trial) begin
      cur.rem  <= REM_W'(part - trial);
      cur.root <= {prev.root[ROOT_W-2:0], 1'b1};
    end else begin
      cur.rem  <= part[REM_W-1:0];
      cur.root <= {prev.root[ROOT_W-2:0], 1'b0};
    end
  end

endmodule

/* src/biped_lateral_leg_kinematics.sv */
// Lateral leg kinematics top level: config registers, offset stage, two
// rows of CORDIC cells and two rows of square-root cells, setpoint holding.
// Depends on bllk_pkg, bllk_if, bllk_cordic_cell, bllk_sqrt_cell.
//
//   channel    dir  payload                                   handshake
//   position   in   hip_position                              valid/ready
//   setpoint   out  in_range, l/r roll, l/r length            valid/ready
//   cfg        in   cfg_index, cfg_data                       cfg_we
//
// One position is in work at a time. The time from accept to setpoint valid
// is set by the length of the CORDIC rows and of the 20-step square-root rows.
// A finished setpoint waits in the output register; a new position is
// accepted as soon as the cell rows are free. rst is synchronous and clears
// the config registers to their defaults and the held setpoints to zero.
module biped_lateral_leg_kinematics import bllk_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  bllk_pos_if.sink          position,
  bllk_set_if.source        setpoint
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int DONE = ((N + 1) > (SQ_STEPS + 2)) ? (N + 1) : (SQ_STEPS + 2);
  localparam int CNT_W = $clog2(DONE + 1);

  // config registers
  logic [REG_W-1:0] hip_height, step_width, hip_width;
  logic signed [POS_W-1:0] right_foot_center;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_height        <= REG_W'(32768);
      step_width        <= REG_W'(13107);
      hip_width         <= REG_W'(6554);
      right_foot_center <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIP_HEIGHT: hip_height        <= cfg_data[REG_W-1:0];
        REG_STEP_WIDTH: step_width        <= cfg_data[REG_W-1:0];
        REG_HIP_WIDTH:  hip_width         <= cfg_data[REG_W-1:0];
        REG_RIGHT_FOOT: right_foot_center <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  logic busy;
  logic [CNT_W-1:0] cnt;
  logic out_valid;
  logic capture;
  logic signed [POS_W-1:0] pos;

  assign position.ready = !busy;
  assign capture = busy && (cnt == CNT_W'(DONE)) && (!out_valid || setpoint.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (position.valid && position.ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (capture) begin
      busy <= 1'b0;
    end else if (busy && cnt != CNT_W'(DONE)) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (position.valid && position.ready) pos <= position.hip_position;
  end

  // offset stage: range check and doubled offsets
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] ofs_r_w, ofs_l_w;
  logic ok_w;
  logic ok;
  logic signed [OFS_W-1:0] ofs_r, ofs_l;
  logic [HGT_W-1:0] h2;

  always_comb begin
    diff = DIFF_W'(pos) - DIFF_W'(right_foot_center);
    ok_w = (diff >= 0) && (diff <= $signed({{(DIFF_W-REG_W){1'b0}}, step_width}));
    ofs_r_w = (diff <<< 1) - $signed({{(DIFF_W-REG_W){1'b0}}, hip_width});
    ofs_l_w = (($signed({{(DIFF_W-REG_W){1'b0}}, step_width}) - diff) <<< 1)
              - $signed({{(DIFF_W-REG_W){1'b0}}, hip_width});
  end

  always_ff @(posedge clk) begin
    ok    <= ok_w;
    ofs_r <= ofs_r_w[OFS_W-1:0];
    ofs_l <= ofs_l_w[OFS_W-1:0];
    h2    <= {hip_height, 1'b0};
  end

  // squares for the length rows
  logic [MAG_W-1:0] mag_r, mag_l;
  logic [SQ_W-1:0] sq_r, sq_l, sq_h;

  always_comb begin
    mag_r = ofs_r[OFS_W-1] ? MAG_W'(-ofs_r) : ofs_r[MAG_W-1:0];
    mag_l = ofs_l[OFS_W-1] ? MAG_W'(-ofs_l) : ofs_l[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    sq_r <= SQ_W'(mag_r) * SQ_W'(mag_r);
    sq_l <= SQ_W'(mag_l) * SQ_W'(mag_l);
    sq_h <= SQ_W'(h2) * SQ_W'(h2);
  end

  // CORDIC rows
  cord_t crd_r [N+1];
  cord_t crd_l [N+1];

  always_comb begin
    crd_r[0].x = $signed({{(CW-HGT_W-8){1'b0}}, h2, 8'b0});
    crd_r[0].y = $signed({{(CW-OFS_W-8){ofs_r[OFS_W-1]}}, ofs_r, 8'b0});
    crd_r[0].z = '0;
    crd_l[0].x = $signed({{(CW-HGT_W-8){1'b0}}, h2, 8'b0});
    crd_l[0].y = $signed({{(CW-OFS_W-8){ofs_l[OFS_W-1]}}, ofs_l, 8'b0});
    crd_l[0].z = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    bllk_cordic_cell #(.STAGE(i)) u_right (.clk(clk), .prev(crd_r[i]), .cur(crd_r[i+1]));
    bllk_cordic_cell #(.STAGE(i)) u_left  (.clk(clk), .prev(crd_l[i]), .cur(crd_l[i+1]));
  end

  // square-root rows
  sq_t sqt_r [SQ_STEPS+1];
  sq_t sqt_l [SQ_STEPS+1];

  always_comb begin
    sqt_r[0].n    = sq_r + sq_h;
    sqt_r[0].rem  = '0;
    sqt_r[0].root = '0;
    sqt_l[0].n    = sq_l + sq_h;
    sqt_l[0].rem  = '0;
    sqt_l[0].root = '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    bllk_sqrt_cell u_right (.clk(clk), .prev(sqt_r[k]), .cur(sqt_r[k+1]));
    bllk_sqrt_cell u_left  (.clk(clk), .prev(sqt_l[k]), .cur(sqt_l[k+1]));
  end

  // final rounding; zero vector gives zero roll
  logic [OUT_W-1:0] roll_r, roll_l;

  always_comb begin
    roll_r = (ofs_r == '0 && h2 == '0) ? '0 : roll_of(crd_r[N].z);
    roll_l = (ofs_l == '0 && h2 == '0) ? '0 : roll_of(crd_l[N].z);
  end

  // held setpoints double as the output register
  logic in_range;
  logic [OUT_W-1:0] held_left_roll, held_right_roll;
  logic [OUT_W-1:0] held_left_length, held_right_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      in_range          <= 1'b0;
      held_left_roll    <= '0;
      held_right_roll   <= '0;
      held_left_length  <= '0;
      held_right_length <= '0;
    end else begin
      if (capture) begin
        out_valid <= 1'b1;
        in_range  <= ok;
        if (ok) begin
          held_left_roll    <= roll_l;
          held_right_roll   <= roll_r;
          held_left_length  <= length_of(sqt_l[SQ_STEPS].root);
          held_right_length <= length_of(sqt_r[SQ_STEPS].root);
        end
      end else if (setpoint.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign setpoint.valid        = out_valid;
  assign setpoint.in_range     = in_range;
  assign setpoint.left_roll    = held_left_roll;
  assign setpoint.right_roll   = held_right_roll;
  assign setpoint.left_length  = held_left_length;
  assign setpoint.right_length = held_right_length;

endmodule

/* src/bllk_checker.sv */
// Port-level checks for the lateral leg kinematics block, bound to the top.
// Depends on bllk_pkg.
module bllk_checker import bllk_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_in_range,
  input logic signed [OUT_W-1:0] out_left_roll,
  input logic signed [OUT_W-1:0] out_right_roll
);

  // a stalled setpoint beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_in_range)
      && $stable(out_left_roll) && $stable(out_right_roll))
    else $error("setpoint changed while stalled");

  // one position in work at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second position accepted while busy");

  // roll stays clamped
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_left_roll <= 18'sd102944 && out_left_roll >= -18'sd102944
      && out_right_roll <= 18'sd102944 && out_right_roll >= -18'sd102944)
    else $error("roll out of range");

  // nothing valid right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind biped_lateral_leg_kinematics bllk_checker u_bllk_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(position.valid),
  .in_ready(position.ready),
  .out_valid(setpoint.valid),
  .out_ready(setpoint.ready),
  .out_in_range(setpoint.in_range),
  .out_left_roll(setpoint.left_roll),
  .out_right_roll(setpoint.right_roll)
);
